// File: rtl/core/psched_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psched_pkg: shared types and constants of the priority scheduler
// Slot record, cell control word, chain operations and result status codes.
// ----------------------------------------------------------------------------
package psched_pkg;

  // Ready store depth and width of the job count
  localparam int QUEUE_DEPTH = 16;
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int COUNT_W     = 5;

  typedef logic [OCC_W-1:0] occ_t;

  // One ready-store entry
  typedef struct packed {
    logic        valid;
    logic [7:0]  id;
    logic [7:0]  urg;
    logic [15:0] left;
    logic [31:0] arrived;
    logic        started;
  } slot_t;

  localparam slot_t SLOT_EMPTY = '0;

  // Chain operations applied by every cell of the row together
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REQUEUE,
    OP_POP
  } op_t;

  // Broadcast control for the row of cells
  typedef struct packed {
    op_t        op;
    logic [7:0] key;
    slot_t      fresh;
  } cell_ctl_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_IDLE     = 3'd2,
    ST_SLICE    = 3'd3,
    ST_FINISHED = 3'd4
  } status_t;

endpackage

// File: rtl/core/psched_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psched_cell: one slot of the sorted ready chain
// Holds one job, compares its urgency with the broadcast key and takes its
// next content from itself, a neighbor or the broadcast slot.
// ----------------------------------------------------------------------------
module psched_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  psched_pkg::cell_ctl_t ctl_i,
  input  psched_pkg::slot_t     lft_slot_i,
  input  logic                  lft_flag_i,
  input  psched_pkg::slot_t     rgt_slot_i,
  input  logic                  rgt_flag_i,
  output psched_pkg::slot_t     slot_o,
  output logic                  flag_o
);

  logic              valid_r, valid_nxt;
  psched_pkg::slot_t data_r, data_nxt;
  psched_pkg::slot_t take;
  logic              own_flag;

  // Flag: this slot lies behind the place where the key job belongs
  assign own_flag = !valid_r || (data_r.urg > ctl_i.key);
  assign flag_o   = own_flag;

  always_comb begin
    take = data_r;
    take.valid = valid_r;
    case (ctl_i.op)
      psched_pkg::OP_INSERT: begin
        // Shift down behind the insert point, load the new job at it
        if (own_flag && !lft_flag_i) begin
          take = ctl_i.fresh;
        end else if (own_flag) begin
          take = lft_slot_i;
        end
      end
      psched_pkg::OP_REQUEUE: begin
        // Head leaves: advance up to the insert point, load the job there
        if (!rgt_flag_i) begin
          take = rgt_slot_i;
        end else if (!own_flag) begin
          take = ctl_i.fresh;
        end
      end
      psched_pkg::OP_POP: begin
        take = rgt_slot_i;
      end
      default: begin
        take.valid = valid_r;
      end
    endcase
    valid_nxt = take.valid;
    data_nxt  = take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_comb begin
    slot_o = data_r;
    slot_o.valid = valid_r;
  end

endmodule

// File: rtl/core/psched_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psched_chain: row of slot cells kept in service order
// Head at cell 0; each cell trades contents and flags with its neighbors.
// ----------------------------------------------------------------------------
module psched_chain (
  input  logic                  clk,
  input  logic                  rst_n,
  input  psched_pkg::cell_ctl_t ctl_i,
  output psched_pkg::slot_t     head_o
);

  psched_pkg::slot_t                   cell_slot [psched_pkg::QUEUE_DEPTH];
  logic [psched_pkg::QUEUE_DEPTH-1:0]  cell_flag;

  // Build the row; the ends see an empty slot and a fixed flag
  for (genvar k = 0; k < psched_pkg::QUEUE_DEPTH; k++) begin : g_cell
    psched_pkg::slot_t lft_slot, rgt_slot;
    logic              lft_flag, rgt_flag;

    if (k == 0) begin : g_first
      assign lft_slot = psched_pkg::SLOT_EMPTY;
      assign lft_flag = 1'b0;
    end else begin : g_mid_l
      assign lft_slot = cell_slot[k-1];
      assign lft_flag = cell_flag[k-1];
    end

    if (k == psched_pkg::QUEUE_DEPTH - 1) begin : g_last
      assign rgt_slot = psched_pkg::SLOT_EMPTY;
      assign rgt_flag = 1'b1;
    end else begin : g_mid_r
      assign rgt_slot = cell_slot[k+1];
      assign rgt_flag = cell_flag[k+1];
    end

    psched_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl_i     (ctl_i),
      .lft_slot_i(lft_slot),
      .lft_flag_i(lft_flag),
      .rgt_slot_i(rgt_slot),
      .rgt_flag_i(rgt_flag),
      .slot_o    (cell_slot[k]),
      .flag_o    (cell_flag[k])
    );
  end

  assign head_o = cell_slot[0];

endmodule

// File: rtl/core/preemptive_priority_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_top: preemptive priority job scheduler
// Arrivals enter a sorted chain of cells if not full; each tick runs the head job
// for one time unit, re-queues it behind equal urgencies or retires it.
//
//   channel | direction | tuser        | tdata
//   in_     | slave     | mode         | process_id, burst_length, priority_req
//   out_    | master    | status       | ran_id, remaining, now_time,
//           |           |              | response_time, first_run, ready_count
//
// Every request is handled in the cycle it is accepted; the result is
// registered and appears on the next cycle, one request per cycle unless stalled.
// The chain updates all slots in parallel: each cell picks its next content
// from its neighbors, so insert and pop-with-requeue are each one update of the row.
// Reset clears the valid bits, time and job count; slot payload is not reset.
// A stalled result holds the input off until out_tready takes it.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // process_id[7:0], burst_length[23:8],
                                  // priority_req[31:24]
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // ran_id[7:0], remaining[23:8],
                                  // now_time[55:24], response_time[87:56],
                                  // first_run[88], ready_count[93:89], zero
  output logic [2:0]  out_tuser   // status
);

  // Request fields
  logic                  in_acc;
  logic                  req_tick;
  logic [7:0]            req_id;
  logic [15:0]           req_burst;
  logic [7:0]            req_urg;

  // State
  logic [31:0]           clock_r, clock_nxt;
  psched_pkg::occ_t      occ_r, occ_nxt;
  logic                  out_valid_r, out_valid_nxt;
  psched_pkg::status_t   status_r, status_nxt;
  logic [7:0]            ran_id_r, ran_id_nxt;
  logic [15:0]           remain_r, remain_nxt;
  logic [31:0]           now_r, now_nxt;
  logic [31:0]           resp_r, resp_nxt;
  logic                  first_r, first_nxt;
  logic [psched_pkg::COUNT_W-1:0] count_r, count_nxt;

  psched_pkg::cell_ctl_t ctl;
  psched_pkg::slot_t     head;
  logic [15:0]           left_dec;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign req_tick  = in_tuser;
  assign req_id    = in_tdata[7:0];
  assign req_burst = in_tdata[23:8];
  assign req_urg   = in_tdata[31:24];

  psched_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl),
    .head_o(head)
  );

  assign left_dec = (head.left != 16'd0) ? (head.left - 16'd1) : 16'd0;

  // Decode the request into a chain operation and a result
  always_comb begin
    ctl           = '0;
    ctl.op        = psched_pkg::OP_HOLD;
    clock_nxt     = clock_r;
    occ_nxt       = occ_r;
    status_nxt    = status_r;
    ran_id_nxt    = ran_id_r;
    remain_nxt    = remain_r;
    resp_nxt      = resp_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (in_acc) begin
      out_valid_nxt = 1'b1;
      ran_id_nxt    = 8'd0;
      remain_nxt    = 16'd0;
      resp_nxt      = 32'd0;
      first_nxt     = 1'b0;
      if (!req_tick) begin
        // Arrival: insert behind equal urgencies unless the store is full
        ran_id_nxt = req_id;
        remain_nxt = req_burst;
        if (occ_r == psched_pkg::occ_t'(psched_pkg::QUEUE_DEPTH)) begin
          status_nxt = psched_pkg::ST_DROPPED;
        end else begin
          status_nxt            = psched_pkg::ST_ACCEPTED;
          ctl.op                = psched_pkg::OP_INSERT;
          ctl.key               = req_urg;
          ctl.fresh.valid       = 1'b1;
          ctl.fresh.id          = req_id;
          ctl.fresh.urg         = req_urg;
          ctl.fresh.left        = req_burst;
          ctl.fresh.arrived     = clock_r;
          ctl.fresh.started     = 1'b0;
          occ_nxt               = occ_r + psched_pkg::occ_t'(1);
        end
      end else if (occ_r == '0) begin
        // Idle tick: advance time only
        status_nxt = psched_pkg::ST_IDLE;
        clock_nxt  = clock_r + 32'd1;
      end else begin
        // Run the head for one unit, then requeue or retire it
        clock_nxt  = clock_r + 32'd1;
        ran_id_nxt = head.id;
        remain_nxt = left_dec;
        if (!head.started) begin
          first_nxt = 1'b1;
          resp_nxt  = clock_r - head.arrived;
        end
        ctl.key = head.urg;
        if (left_dec != 16'd0) begin
          status_nxt        = psched_pkg::ST_SLICE;
          ctl.op            = psched_pkg::OP_REQUEUE;
          ctl.fresh         = head;
          ctl.fresh.valid   = 1'b1;
          ctl.fresh.left    = left_dec;
          ctl.fresh.started = 1'b1;
        end else begin
          status_nxt = psched_pkg::ST_FINISHED;
          ctl.op     = psched_pkg::OP_POP;
          occ_nxt    = occ_r - psched_pkg::occ_t'(1);
        end
      end
    end

    now_nxt   = in_acc ? clock_nxt : now_r;
    count_nxt = in_acc ? psched_pkg::COUNT_W'(occ_nxt) : count_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r     <= 32'd0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clock_r     <= clock_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    ran_id_r <= ran_id_nxt;
    remain_r <= remain_nxt;
    now_r    <= now_nxt;
    resp_r   <= resp_nxt;
    first_r  <= first_nxt;
    count_r  <= count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {2'b00, count_r, first_r, resp_r, now_r, remain_r, ran_id_r};

endmodule

// File: bench/preemptive_priority_scheduler_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_checker: scoreboard for the priority scheduler
// Watches both stream channels, predicts one result per accepted request from
// its own copy of the ready store and time, and compares the results in order.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_checker #(
  parameter logic TICK_MODE = 1'b1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // process_id[7:0], burst_length[23:8],
                                  // priority_req[31:24]
  input  logic        in_tuser,   // mode
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [95:0] out_tdata,  // ran_id[7:0], remaining[23:8],
                                  // now_time[55:24], response_time[87:56],
                                  // first_run[88], ready_count[93:89], zero
  input  logic [2:0]  out_tuser,  // status
  output int          mismatches,
  output int          awaited,
  output int          jobs_waiting,
  output int          requests_seen,
  output int          results_seen,
  output int          finished_seen,
  output int          dropped_seen,
  output int          idle_seen
);

  // One predicted result
  typedef struct packed {
    psched_pkg::status_t status;
    logic [7:0]          id;
    logic [15:0]         left;
    logic [31:0]         stamp;
    logic [31:0]         wait_time;
    logic                first;
    logic [4:0]          count;
  } outcome_t;

  // Model of the ready store, kept in service order with the head at 0
  psched_pkg::slot_t ready_jobs [psched_pkg::QUEUE_DEPTH];
  int unsigned       job_count;
  logic [31:0]       sched_clock;
  outcome_t          outcome_q[$];

  // Insert a job behind every waiting job of equal or more urgent priority
  function automatic void queue_job(input psched_pkg::slot_t job);
    int pos;
    pos = 0;
    while (pos < job_count && ready_jobs[pos].urg <= job.urg) pos++;
    for (int k = job_count; k > pos; k--) ready_jobs[k] = ready_jobs[k-1];
    ready_jobs[pos] = job;
    job_count++;
  endfunction

  // Apply one request to the model and return the result it causes
  function automatic outcome_t schedule_request(input logic tick, input logic [7:0] pid,
                                                input logic [15:0] burst,
                                                input logic [7:0] urg);
    outcome_t          res;
    psched_pkg::slot_t job;
    res = '0;
    job = '0;
    if (!tick) begin
      res.id   = pid;
      res.left = burst;
      if (job_count >= psched_pkg::QUEUE_DEPTH) begin
        res.status = psched_pkg::ST_DROPPED;
      end else begin
        job.valid   = 1'b1;
        job.id      = pid;
        job.urg     = urg;
        job.left    = burst;
        job.arrived = sched_clock;
        queue_job(job);
        res.status = psched_pkg::ST_ACCEPTED;
      end
    end else if (job_count == 0) begin
      res.status  = psched_pkg::ST_IDLE;
      sched_clock = sched_clock + 32'd1;
    end else begin
      // pop the head, run it one unit, then requeue or retire it
      job = ready_jobs[0];
      for (int k = 0; k + 1 < job_count; k++) ready_jobs[k] = ready_jobs[k+1];
      job_count--;
      if (!job.started) begin
        res.first     = 1'b1;
        res.wait_time = sched_clock - job.arrived;
      end
      sched_clock = sched_clock + 32'd1;
      if (job.left != 16'd0) job.left = job.left - 16'd1;
      res.id   = job.id;
      res.left = job.left;
      if (job.left != 16'd0) begin
        job.started = 1'b1;
        queue_job(job);
        res.status = psched_pkg::ST_SLICE;
      end else begin
        res.status = psched_pkg::ST_FINISHED;
      end
    end
    res.stamp = sched_clock;
    res.count = job_count[4:0];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got, inout bit bad);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
      bad = 1'b1;
    end
  endtask

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    outcome_t want;
    bit       bad;
    if (!rst_n) begin
      job_count   = 0;
      sched_clock = '0;
      outcome_q.delete();
      for (int k = 0; k < psched_pkg::QUEUE_DEPTH; k++) ready_jobs[k] = '0;
    end else begin
      if (in_tvalid && in_tready) begin
        outcome_q.push_back(schedule_request(in_tuser == TICK_MODE, in_tdata[7:0],
                                             in_tdata[23:8], in_tdata[31:24]));
        requests_seen++;
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (outcome_q.size() == 0) begin
          $display("%0t: result with none expected, status %0d tdata 0x%h",
                   $time, out_tuser, out_tdata);
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          bad  = 1'b0;
          check_field("status", 32'(want.status), 32'(out_tuser), bad);
          check_field("ran_id", 32'(want.id), 32'(out_tdata[7:0]), bad);
          check_field("remaining", 32'(want.left), 32'(out_tdata[23:8]), bad);
          check_field("now_time", want.stamp, out_tdata[55:24], bad);
          check_field("response_time", want.wait_time, out_tdata[87:56], bad);
          check_field("first_run", 32'(want.first), 32'(out_tdata[88]), bad);
          check_field("ready_count", 32'(want.count), 32'(out_tdata[93:89]), bad);
          check_field("tdata padding", 32'd0, 32'(out_tdata[95:94]), bad);
          if (bad) mismatches++;
          case (want.status)
            psched_pkg::ST_FINISHED: finished_seen++;
            psched_pkg::ST_DROPPED:  dropped_seen++;
            psched_pkg::ST_IDLE:     idle_seen++;
            default: ;
          endcase
        end
      end
    end
    awaited      <= outcome_q.size();
    jobs_waiting <= job_count;
  end

endmodule

// File: bench/preemptive_priority_scheduler_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_top_test: stimulus and verdict for the scheduler
// Drives arrival and tick requests with random gaps and output stalls, fills
// and overflows the ready store, and lets the checker score every result.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_top_test;

  localparam logic MODE_ARRIVE  = 1'b0;
  localparam logic MODE_TICK    = 1'b1;
  localparam int   RANDOM_ITEMS = 1050;
  localparam int   CYCLE_LIMIT  = 500000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // process_id[7:0], burst_length[23:8], priority_req[31:24]
  logic        in_tuser;   // mode
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;  // ran_id[7:0], remaining[23:8], now_time[55:24],
                           // response_time[87:56], first_run[88],
                           // ready_count[93:89], zero
  logic [2:0]  out_tuser;  // status

  int mismatches, awaited, jobs_waiting, requests_seen, results_seen;
  int finished_seen, dropped_seen, idle_seen;
  int sent_count;
  int cycle_count;
  int hold_cycles;
  bit steady;

  preemptive_priority_scheduler_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  preemptive_priority_scheduler_checker #(
    .TICK_MODE (MODE_TICK)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .mismatches    (mismatches),
    .awaited       (awaited),
    .jobs_waiting  (jobs_waiting),
    .requests_seen (requests_seen),
    .results_seen  (results_seen),
    .finished_seen (finished_seen),
    .dropped_seen  (dropped_seen),
    .idle_seen     (idle_seen)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, awaited);
      $display("preemptive_priority_scheduler_top_test: FAIL");
      $finish;
    end
  end

  // Result side: random stalls unless steady, or one long hold-off when requested
  initial begin
    int n;
    bit held;
    held       = 1'b0;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles != 0 && !held) begin
        n    = hold_cycles;
        held = 1'b1;
      end else begin
        n = steady ? 0 : $urandom_range(0, 3);
      end
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Offer one request after a random gap, none if steady, and hold it until accepted
  task automatic offer(input logic mode, input logic [7:0] pid,
                       input logic [15:0] burst, input logic [7:0] urg);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {urg, burst, pid};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
  endtask

  // Stop offering until every expected result has been taken
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
  endtask

  // Random request: a tick or an arrival, mostly short bursts and close urgencies
  task automatic offer_random(input int arrive_pct);
    logic [15:0] burst;
    logic [7:0]  urg;
    int          pick;
    if ($urandom_range(1, 100) > arrive_pct) begin
      offer(MODE_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 5)       burst = 16'd0;
      else if (pick < 85) burst = 16'($urandom_range(1, 6));
      else                burst = 16'($urandom_range(7, 20));
      urg = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      offer(MODE_ARRIVE, 8'($urandom), burst, urg);
    end
  endtask

  // Fill the store to the top, then push arrivals that must be dropped
  task automatic overfill_store();
    int room;
    wait_drained();
    room = psched_pkg::QUEUE_DEPTH - jobs_waiting;
    repeat (room) offer(MODE_ARRIVE, 8'($urandom), 16'($urandom_range(1, 4)), 8'($urandom));
    repeat (3) offer(MODE_ARRIVE, 8'($urandom), 16'($urandom), 8'($urandom));
    offer(MODE_ARRIVE, 8'hFF, 16'hFFFF, 8'h00);
  endtask

  initial begin
    int phase;
    int arrive_pct;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = MODE_ARRIVE;
    steady      = 1'b0;
    hold_cycles = 0;
    sent_count  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle tick, zero burst, extreme urgencies, equal-urgency order
    offer(MODE_TICK,   8'hFF, 16'hFFFF, 8'hFF);
    offer(MODE_ARRIVE, 8'h00, 16'd1,    8'hFF);
    offer(MODE_ARRIVE, 8'hA5, 16'd0,    8'h00);
    offer(MODE_ARRIVE, 8'h11, 16'd2,    8'h05);
    offer(MODE_ARRIVE, 8'h12, 16'd1,    8'h05);
    offer(MODE_TICK,   8'h00, 16'h0000, 8'h00);
    repeat (4) offer(MODE_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
    offer(MODE_TICK,   8'h5A, 16'h5A5A, 8'h5A);
    offer(MODE_ARRIVE, 8'h7E, 16'd3,    8'h80);
    offer(MODE_ARRIVE, 8'h7F, 16'd1,    8'h80);
    offer(MODE_ARRIVE, 8'h81, 16'd2,    8'h7F);
    repeat (6) offer(MODE_TICK, 8'($urandom), 16'($urandom), 8'($urandom));

    // Random phases with varying arrival mix, idling, hold-off and overflow
    phase = 0;
    while (sent_count < RANDOM_ITEMS) begin
      steady     = ($urandom_range(0, 3) == 0);
      arrive_pct = 35 + 15 * $urandom_range(0, 2);
      if (phase == 2) hold_cycles = 80;
      if (phase % 5 == 4) overfill_store();
      repeat ($urandom_range(30, 70)) offer_random(arrive_pct);
      phase++;
    end

    // Drain the store with ticks, then run one job of the longest burst
    steady = 1'b0;
    wait_drained();
    while (jobs_waiting != 0) begin
      repeat (16) offer(MODE_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
      wait_drained();
    end
    offer(MODE_ARRIVE, 8'h5A, 16'hFFFF, 8'hFF);
    repeat (3) offer(MODE_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Ran %0d requests in %0d phases, %0d results checked.",
             requests_seen, phase, results_seen);
    $display("Seen %0d finished jobs, %0d dropped arrivals, %0d idle ticks.",
             finished_seen, dropped_seen, idle_seen);
    if (mismatches == 0 && awaited == 0) begin
      $display("preemptive_priority_scheduler_top_test: PASS");
    end else begin
      $display("%0d mismatching results, %0d results never arrived", mismatches, awaited);
      $display("preemptive_priority_scheduler_top_test: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/psched_pkg.sv
rtl/core/psched_cell.sv
rtl/core/psched_chain.sv
rtl/core/preemptive_priority_scheduler_top.sv
bench/preemptive_priority_scheduler_checker.sv
bench/preemptive_priority_scheduler_top_test.sv
